/* hdl/daubechies_d4_wavelet_transform_core_assert.svh */
// Assertion macros shared by the checker of the D4 wavelet core.
// Depends on nothing; the including file supplies clk and arst_n.
`ifndef DAUBECHIES_D4_WAVELET_TRANSFORM_CORE_ASSERT_SVH
`define DAUBECHIES_D4_WAVELET_TRANSFORM_CORE_ASSERT_SVH
// Implication checked on every rising edge outside of reset.
`define D4_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define D4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hdl/dwt_pkg.sv */
// Shared constants and helpers of the D4 wavelet core.
// Depends on nothing; used by the datapath and the top level.
package dwt_pkg;
	localparam int MAX_LEN = 64;
	localparam int SAMPLE_BITS = 24;
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = AW + 1;
	localparam int LOG_MAX = $clog2(MAX_LEN);
	localparam logic signed [16:0] C_H0 = 17'sd15826;
	localparam logic signed [16:0] C_H1 = 17'sd27411;
	localparam logic signed [16:0] C_H2 = 17'sd7345;
	localparam logic signed [16:0] C_H3 = -17'sd4240;
	localparam int PW = SAMPLE_BITS + 17;
	localparam int SW = SAMPLE_BITS - 15 + 3 + 17;

	localparam logic [0:0] REG_DIRECTION = 1'b0;
	localparam logic [0:0] REG_LENGTH = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] word_t;

	// Coefficient of tap t for output row r (0 even/smooth, 1 odd/detail).
	function automatic logic signed [16:0] coef(input logic inv, input logic r,
			input logic [1:0] t);
		logic signed [16:0] c;
		begin
			c = C_H0;
			if (!inv) begin
				case ({r, t})
					3'd0: c = C_H0;
					3'd1: c = C_H1;
					3'd2: c = C_H2;
					3'd3: c = C_H3;
					3'd4: c = C_H3;
					3'd5: c = -C_H2;
					3'd6: c = C_H1;
					3'd7: c = -C_H0;
					default: c = C_H0;
				endcase
			end else begin
				case ({r, t})
					3'd0: c = C_H2;
					3'd1: c = C_H1;
					3'd2: c = C_H0;
					3'd3: c = C_H3;
					3'd4: c = C_H3;
					3'd5: c = -C_H0;
					3'd6: c = C_H1;
					3'd7: c = -C_H2;
					default: c = C_H0;
				endcase
			end
			return c;
		end
	endfunction
endpackage

/* hdl/dwt_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module dwt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/dwt_mac.sv */
// One rounded product per cycle while en is high, into an accumulator whose output saturates.
// Depends on dwt_pkg.
module dwt_mac import dwt_pkg::*; (
	input logic clk,
	input logic clr,
	input logic en,
	input word_t x,
	input logic signed [16:0] c,
	output word_t sat
);
	logic signed [PW-1:0] prod;
	logic signed [SW-1:0] rp;
	logic signed [SW-1:0] acc_q;
	logic signed [SW-1:0] hi, lo;

	always_comb begin
		prod = PW'(x) * PW'(c) + PW'(16384);
		rp = SW'(prod >>> 15);
		hi = SW'((1 <<< (SAMPLE_BITS - 1)) - 1);
		lo = -hi - SW'(1);
		if (acc_q > hi) sat = word_t'(hi);
		else if (acc_q < lo) sat = word_t'(lo);
		else sat = word_t'(acc_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= (clr ? SW'(0) : acc_q) + rp;
		end
	end
endmodule

/* hdl/daubechies_d4_wavelet_transform_core.sv */
// Daubechies D4 wavelet core: loads a block, transforms it level by level in
// two RAMs, then streams it out. Depends on dwt_pkg, dwt_ram and dwt_mac.
// Load takes one sample word per cycle while no result word is on offer. Each
// level runs the multiply-accumulate of every output word on one shared
// multiplier, then copies the level back from the scratch RAM. Output passes
// through ST_WAIT and ST_OUT per word. Input stays stalled until the last word leaves.
// Reset clears control state and the registers; RAM contents are undefined.
module daubechies_d4_wavelet_transform_core import dwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input logic out_stall,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic last,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [2:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_MAC = 5'b00010,
		ST_COPY = 5'b00100,
		ST_OUT = 5'b01000,
		ST_WAIT = 5'b10000
	} state_t;

	state_t state_q;
	logic dir_q;
	logic [2:0] lenlog_q;
	logic [CW-1:0] cnt_q;
	logic [2:0] nlog_q;
	logic [2:0] curlog_q;
	logic [AW-1:0] idx_q;
	logic row_q;
	logic [2:0] tap_q;
	logic [AW:0] cp_q;
	logic [2:0] eff_log;

	logic a_we, s_we;
	logic [AW-1:0] a_wa, a_ra, s_wa, s_ra;
	word_t a_wd, a_rd, s_rd, sat;
	logic mac_en, mac_clr;
	logic [1:0] tap_d_q;
	logic row_d_q;
	logic mac_v_q;
	logic mac_done_q;
	logic [AW-1:0] wr_idx_q;
	logic wr_row_q;

	dwt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_blk (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
	dwt_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_scr (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(sat), .raddr(s_ra), .rdata(s_rd));
	dwt_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .x(a_rd),
		.c(coef(dir_q, row_d_q, tap_d_q)), .sat(sat));

	always_comb begin
		eff_log = lenlog_q;
		if (eff_log < 3'd2) eff_log = 3'd2;
		if (eff_log > 3'(LOG_MAX)) eff_log = 3'(LOG_MAX);
	end

	// Address arithmetic for the current level.
	logic [AW:0] n_cur, half_cur;
	logic [AW:0] j, s0, s1, rd_addr;
	always_comb begin
		n_cur = (AW+1)'(1) << curlog_q;
		half_cur = n_cur >> 1;
		j = {idx_q, 1'b0};
		s0 = (idx_q == '0) ? half_cur - 1'b1 : (AW+1)'(idx_q) - 1'b1;
		s1 = (s0 + 1'b1 == half_cur) ? '0 : s0 + 1'b1;
		rd_addr = '0;
		if (!dir_q) begin
			rd_addr = (j + (AW+1)'(tap_q[1:0])) & (n_cur - 1'b1);
		end else begin
			case (tap_q[1:0])
				2'd0: rd_addr = s0;
				2'd1: rd_addr = s0 + half_cur;
				2'd2: rd_addr = s1;
				default: rd_addr = s1 + half_cur;
			endcase
		end
	end

	// The final word of a block may still wait on the output; hold input until it leaves.
	assign in_stall = (state_q != ST_LOAD) || out_valid;
	assign a_we = (state_q == ST_LOAD && in_valid && !out_valid) ||
		(state_q == ST_COPY && cp_q != '0);
	assign a_wa = (state_q == ST_LOAD) ? cnt_q[AW-1:0] : AW'(cp_q - 1'b1);
	assign a_wd = (state_q == ST_LOAD) ? sample : s_rd;
	assign a_ra = (state_q == ST_OUT || state_q == ST_WAIT) ? cnt_q[AW-1:0] : rd_addr[AW-1:0];
	assign s_ra = cp_q[AW-1:0];
	assign mac_en = mac_v_q;
	assign mac_clr = mac_v_q && tap_d_q == 2'd0;
	assign s_we = mac_done_q;
	assign s_wa = !dir_q ? (wr_row_q ? AW'((AW+1)'(wr_idx_q) + half_cur) : wr_idx_q)
		: AW'({wr_idx_q, wr_row_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			dir_q <= 1'b0;
			lenlog_q <= 3'd6;
			cnt_q <= '0;
			nlog_q <= 3'd2;
			curlog_q <= 3'd2;
			idx_q <= '0;
			row_q <= 1'b0;
			tap_q <= '0;
			cp_q <= '0;
			mac_v_q <= 1'b0;
			mac_done_q <= 1'b0;
			tap_d_q <= '0;
			row_d_q <= 1'b0;
			wr_idx_q <= '0;
			wr_row_q <= 1'b0;
			out_valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIRECTION: dir_q <= cfg_data[0];
					REG_LENGTH: lenlog_q <= cfg_data;
					default: ;
				endcase
			end
			mac_v_q <= 1'b0;
			mac_done_q <= 1'b0;
			tap_d_q <= tap_q[1:0];
			row_d_q <= row_q;
			wr_idx_q <= idx_q;
			wr_row_q <= row_q;
			case (state_q)
				ST_LOAD: begin
					if (in_valid && !out_valid) begin
						if (cnt_q + 1'b1 >= (CW'(1) << eff_log)) begin
							cnt_q <= '0;
							nlog_q <= eff_log;
							curlog_q <= dir_q ? 3'd2 : eff_log;
							idx_q <= '0;
							row_q <= 1'b0;
							tap_q <= '0;
							state_q <= ST_MAC;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_MAC: begin
					// Taps 0..3 issue reads; tap 4 lets the last product land.
					if (tap_q < 3'd4) begin
						mac_v_q <= 1'b1;
						tap_q <= tap_q + 1'b1;
					end else if (tap_q == 3'd4) begin
						tap_q <= 3'd5;
					end else begin
						mac_done_q <= 1'b1;
						tap_q <= '0;
						row_q <= ~row_q;
						if (row_q) begin
							if ((AW+1)'(idx_q) + 1'b1 == half_cur) begin
								idx_q <= '0;
								cp_q <= '0;
								state_q <= ST_COPY;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				ST_COPY: begin
					if (cp_q == n_cur) begin
						idx_q <= '0;
						if ((!dir_q && curlog_q == 3'd2) || (dir_q && curlog_q == nlog_q)) begin
							cnt_q <= '0;
							state_q <= ST_WAIT;
						end else begin
							curlog_q <= dir_q ? curlog_q + 1'b1 : curlog_q - 1'b1;
							state_q <= ST_MAC;
						end
					end else begin
						cp_q <= cp_q + 1'b1;
					end
				end
				ST_WAIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						if (!out_valid || cnt_q != '0 || !last) begin
							out_valid <= 1'b1;
							value <= a_rd;
							last <= (cnt_q + 1'b1 == (CW'(1) << nlog_q));
							if (cnt_q + 1'b1 == (CW'(1) << nlog_q)) begin
								cnt_q <= '0;
								state_q <= ST_LOAD;
							end else begin
								cnt_q <= cnt_q + 1'b1;
								state_q <= ST_WAIT;
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
			if (out_valid && !out_stall && !(state_q == ST_OUT)) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

/* hdl/dwt_checker.sv */
// Port-level checker for the D4 wavelet core, bound to the top level.
// Depends on dwt_pkg and the assertion macro header.
`include "daubechies_d4_wavelet_transform_core_assert.svh"
module dwt_checker import dwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [SAMPLE_BITS-1:0] value,
	input logic last
);
	// No input is taken while a result word is on offer.
	`D4_ASSERT_IMP(no_load_while_out, in_valid && !in_stall, !out_valid)
	// A stalled result word holds its value.
	`D4_ASSERT_NEXT(out_hold, out_valid && out_stall, out_valid && $stable(value))
	// After the final word leaves, loading resumes.
	`D4_ASSERT_NEXT(load_after_last, out_valid && !out_stall && last, !out_valid)
endmodule

bind daubechies_d4_wavelet_transform_core dwt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .value(value), .last(last));

/* dv/tb_top.sv */
// Self-checking bench for the D4 wavelet core: directed and random blocks,
// forward and inverse, checked word by word. Depends on dwt_pkg and the core.
`timescale 1ns / 100ps
module tb_top;
	import dwt_pkg::*;

	localparam int TIMEOUT_CYCLES = 900000;
	localparam logic signed [16:0] K0 = 17'sd15826;
	localparam logic signed [16:0] K1 = 17'sd27411;
	localparam logic signed [16:0] K2 = 17'sd7345;
	localparam logic signed [16:0] K3 = -17'sd4240;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	word_t sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	word_t value;
	logic last;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_DIRECTION;
	logic [2:0] cfg_data = '0;

	daubechies_d4_wavelet_transform_core i_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct packed {
		word_t v;
		logic l;
	} out_word_t;

	out_word_t expected_words[$];
	longint coeff_block[MAX_LEN];
	longint level_buf[MAX_LEN];
	int loaded;
	logic dir_reg;
	logic [2:0] len_reg;
	int mismatches = 0;
	int cycles = 0;

	function automatic longint rnd_mul(longint x, longint c);
		return (x * c + 16384) >>> 15;
	endfunction

	function automatic longint sat_sum(longint a, longint b, longint c, longint d,
			longint k0, longint k1, longint k2, longint k3);
		longint s;
		s = rnd_mul(a, k0) + rnd_mul(b, k1) + rnd_mul(c, k2) + rnd_mul(d, k3);
		if (s > 8388607) s = 8388607;
		if (s < -8388608) s = -8388608;
		return s;
	endfunction

	function automatic int cur_len();
		int lg;
		lg = len_reg;
		if (lg < 2) lg = 2;
		if (lg > LOG_MAX) lg = LOG_MAX;
		return 1 << lg;
	endfunction

	// Load one word; on the final one of a block run all levels and queue the block.
	task automatic predict_word(word_t s);
		int n, m, h, i, j, s0, s1;
		longint a, b, c, d;
		n = cur_len();
		if (loaded >= MAX_LEN) loaded = 0;
		coeff_block[loaded] = s;
		loaded++;
		if (loaded < n) return;
		loaded = 0;
		m = dir_reg ? 4 : n;
		while (m >= 4 && m <= n) begin
			h = m / 2;
			for (i = 0; i < h; i++) begin
				if (!dir_reg) begin
					j = 2 * i;
					a = coeff_block[j]; b = coeff_block[j+1];
					c = coeff_block[(j+2)%m]; d = coeff_block[(j+3)%m];
					level_buf[i] = sat_sum(a, b, c, d, K0, K1, K2, K3);
					level_buf[i+h] = sat_sum(a, b, c, d, K3, -K2, K1, -K0);
				end else begin
					s0 = (i + h - 1) % h;
					s1 = (s0 + 1) % h;
					a = coeff_block[s0]; b = coeff_block[s0+h];
					c = coeff_block[s1]; d = coeff_block[s1+h];
					level_buf[2*i] = sat_sum(a, b, c, d, K2, K1, K0, K3);
					level_buf[2*i+1] = sat_sum(a, b, c, d, K3, -K0, K1, -K2);
				end
			end
			for (i = 0; i < m; i++) coeff_block[i] = level_buf[i];
			m = dir_reg ? m * 2 : m / 2;
		end
		for (i = 0; i < n; i++)
			expected_words.push_back('{v: word_t'(coeff_block[i]), l: (i == n - 1)});
	endtask

	task automatic write_reg(logic [0:0] idx, logic [2:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIRECTION) dir_reg = d[0];
		else len_reg = d;
	endtask

	task automatic send_word(word_t s);
		sample <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_word(s);
	endtask

	// Sender bursts: after a burst ends, valid drops for a random gap in two of three cases.
	int burst_left = 0;
	task automatic send_paced(word_t s);
		int g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) != 0) begin
				g = $urandom_range(1, 12);
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		send_word(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// Receiver stall pattern: alternating free and stalling stretches.
	int stall_left = 0;
	logic stall_mode = 1'b0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= ~stall_mode;
			stall_left <= stall_mode ? $urandom_range(5, 60) : $urandom_range(1, 8);
			out_stall <= 1'b0;
		end else begin
			stall_left <= stall_left - 1;
			out_stall <= stall_mode ? ($urandom_range(0, 1) == 1) : 1'b0;
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word value=%0d last=%0b", value, last);
			end else begin
				want = expected_words.pop_front();
				if (want.v !== value || want.l !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: expected %0d/%0b got %0d/%0b",
							want.v, want.l, value, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Directed rows: direction, length_log2, value pattern (0 zero, 1 max, 2 min, 3 alt).
	typedef struct {
		logic dir;
		logic [2:0] lg;
		int pat;
	} dir_row_t;
	dir_row_t dir_rows[8] = '{
		'{1'b0, 3'd2, 0}, '{1'b0, 3'd2, 1}, '{1'b0, 3'd2, 2}, '{1'b1, 3'd2, 3},
		'{1'b0, 3'd0, 3}, '{1'b1, 3'd7, 1}, '{1'b0, 3'd6, 3}, '{1'b1, 3'd3, 2}
	};

	initial begin
		int r, i, n, blocks;
		word_t s;
		dir_reg = 1'b0;
		len_reg = 3'd6;
		loaded = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < 8; r++) begin
			write_reg(REG_DIRECTION, {2'b0, dir_rows[r].dir});
			write_reg(REG_LENGTH, dir_rows[r].lg);
			n = cur_len();
			for (i = 0; i < n; i++) begin
				case (dir_rows[r].pat)
					0: s = '0;
					1: s = 24'sh7fffff;
					2: s = -24'sh800000;
					default: s = i[0] ? -24'sh800000 : 24'sh7fffff;
				endcase
				send_word(s);
			end
			drain();
		end
		// Random blocks, mostly short lengths, with full-scale and small values.
		blocks = 0;
		while (blocks < 16) begin
			write_reg(REG_DIRECTION, {2'b0, 1'($urandom_range(0, 1))});
			write_reg(REG_LENGTH, ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(2, 4)));
			n = cur_len();
			for (i = 0; i < n; i++) begin
				s = ($urandom_range(0, 1) == 1) ? word_t'($urandom)
					: word_t'($signed(10'($urandom)));
				send_paced(s);
			end
			drain();
			blocks++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/dwt_pkg.sv
hdl/dwt_ram.sv
hdl/dwt_mac.sv
hdl/daubechies_d4_wavelet_transform_core.sv
hdl/dwt_checker.sv
dv/tb_top.sv
